@@ hdl/tif_pkg.sv @@
// Shared types, codes and defaults for the tensor index-fill block.
package tif_pkg;

    localparam int DATA_WIDTH           = 64;
    localparam int DEF_MAX_DIM_SIZE     = 4096;
    localparam int DEF_INNER_WIDTH      = 24;

    localparam int DIM_SIZE_W           = 13;
    localparam int INNER_SIZE_W         = 25;
    localparam int CFG_DATA_W           = 64;
    localparam int CFG_INDEX_W          = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIM_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_VALUE = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_DATA  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] index_in;
        logic [63:0]        data_in;
        logic               last_in;
    } tif_in_t;

    typedef struct packed {
        logic [63:0] data_out;
        logic        last_out;
        logic        status;
    } tif_out_t;

endpackage

@@ hdl/tensor_index_fill.sv @@
// Top level of the tensor index-fill block: mark memory, position counters, output stage.
// An accepted request is held in the p1 registers and its result in the output register.
// Throughput: one request per cycle unless the output stalls; mark rows are read at
// accept, written back as p1 advances, and forwarded to a following read of the same row.
// Reset (synchronous, aresetn low) loads the register defaults, zeroes both counters and
// clears every mark at once through one valid bit per memory row, as a clear request does.
module tensor_index_fill
    import tif_pkg::*;
#(
    parameter int MAX_DIM_SIZE = DEF_MAX_DIM_SIZE,
    parameter int INNER_WIDTH  = DEF_INNER_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tif_in_t                s_req,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tif_out_t               m_rsp
);

    localparam int POS_W     = (MAX_DIM_SIZE > 1) ? $clog2(MAX_DIM_SIZE) : 1;
    localparam int WB_W      = (POS_W > 12) ? POS_W - 7 : 5;
    localparam int ROW_W     = (POS_W > WB_W) ? POS_W - WB_W : 1;
    localparam int ADDR_W    = WB_W + ROW_W;
    localparam int WORD_BITS = 1 << WB_W;
    localparam int ROWS      = 1 << ROW_W;

    localparam logic [63:0] DATA_MASK = {64{1'b1}} >> (64 - DATA_WIDTH);

    logic [DIM_SIZE_W-1:0]   dim_size_reg;
    logic [INNER_SIZE_W-1:0] inner_size_reg;
    logic [63:0]             fill_value_reg;

    logic [INNER_WIDTH-1:0]  inner_count_reg, inner_count_next;
    logic [POS_W-1:0]        dim_position_reg, dim_position_next;

    logic [WORD_BITS-1:0]    mark_mem [ROWS];
    logic [ROWS-1:0]         row_valid_reg, row_valid_next;
    logic [WORD_BITS-1:0]    rd_data_reg;
    logic [WORD_BITS-1:0]    last_wdata_reg;

    logic                    p1_valid_reg;
    logic [1:0]              p1_op_reg;
    logic [63:0]             p1_data_reg;
    logic                    p1_last_reg;
    logic                    p1_bad_reg;
    logic [ROW_W-1:0]        p1_row_reg;
    logic [WB_W-1:0]         p1_bit_reg;
    logic                    p1_fwd_reg;
    logic                    p1_rvalid_reg;

    tif_out_t                out_reg, out_next;
    logic                    out_valid_reg;

    logic                    out_free;
    logic                    p1_adv;
    logic                    s_accept;
    logic                    mem_we;

    logic [POS_W:0]          eff_dim;
    logic [16:0]             dsz_x;
    logic [INNER_WIDTH:0]    eff_inner;
    logic [33:0]             isz_x;
    logic [33:0]             inner_lim;

    logic signed [17:0]      idx_x;
    logic signed [17:0]      d_x;
    logic signed [17:0]      norm_x;
    logic                    idx_bad;
    logic [ADDR_W-1:0]       s_addr;
    logic [ROW_W-1:0]        s_row;
    logic [WB_W-1:0]         s_bit;

    logic [WORD_BITS-1:0]    merged_row;
    logic [WORD_BITS-1:0]    p1_wdata;
    logic                    mark_hit;

    assign out_free = !out_valid_reg || m_ready;
    assign p1_adv   = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;
    assign mem_we   = p1_adv && (p1_op_reg == OP_ADD) && !p1_bad_reg;

    assign m_valid  = out_valid_reg;
    assign m_rsp    = out_reg;

    always_comb begin
        dsz_x = 17'(dim_size_reg);
        if (dsz_x == 17'd0) begin
            eff_dim = (POS_W+1)'(1);
        end else if (dsz_x > 17'(MAX_DIM_SIZE)) begin
            eff_dim = (POS_W+1)'(MAX_DIM_SIZE);
        end else begin
            eff_dim = (POS_W+1)'(dsz_x);
        end

        isz_x     = 34'(inner_size_reg);
        inner_lim = 34'(1) << INNER_WIDTH;
        if (isz_x == 34'd0) begin
            eff_inner = (INNER_WIDTH+1)'(1);
        end else if (isz_x > inner_lim) begin
            eff_inner = (INNER_WIDTH+1)'(inner_lim);
        end else begin
            eff_inner = (INNER_WIDTH+1)'(isz_x);
        end
    end

    always_comb begin
        idx_x   = {{2{s_req.index_in[15]}}, s_req.index_in};
        d_x     = {1'b0, 17'(eff_dim)};
        idx_bad = (idx_x < -d_x) || (idx_x >= d_x);
        norm_x  = idx_x[17] ? idx_x + d_x : idx_x;
        if (s_req.opcode == OP_ADD) begin
            s_addr = ADDR_W'(norm_x);
        end else begin
            s_addr = ADDR_W'(dim_position_reg);
        end
        s_row = s_addr[ADDR_W-1:WB_W];
        s_bit = s_addr[WB_W-1:0];
    end

    // advance the element coordinate on data, restart on clear or last element
    always_comb begin
        inner_count_next  = inner_count_reg;
        dim_position_next = dim_position_reg;
        if (s_accept) begin
            case (s_req.opcode)
                OP_CLEAR: begin
                    inner_count_next  = '0;
                    dim_position_next = '0;
                end
                OP_DATA: begin
                    if (s_req.last_in) begin
                        inner_count_next  = '0;
                        dim_position_next = '0;
                    end else if (({1'b0, inner_count_reg} + (INNER_WIDTH+1)'(1)) >= eff_inner)
                    begin
                        inner_count_next = '0;
                        if (({1'b0, dim_position_reg} + (POS_W+1)'(1)) >= eff_dim) begin
                            dim_position_next = '0;
                        end else begin
                            dim_position_next = dim_position_reg + POS_W'(1);
                        end
                    end else begin
                        inner_count_next = inner_count_reg + INNER_WIDTH'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        row_valid_next = row_valid_reg;
        if (mem_we) begin
            row_valid_next[p1_row_reg] = 1'b1;
        end
        if (s_accept && (s_req.opcode == OP_CLEAR)) begin
            row_valid_next = '0;
        end
    end

    always_comb begin
        if (p1_fwd_reg) begin
            merged_row = last_wdata_reg;
        end else if (p1_rvalid_reg) begin
            merged_row = rd_data_reg;
        end else begin
            merged_row = '0;
        end
        p1_wdata = merged_row | (WORD_BITS'(1) << p1_bit_reg);
        mark_hit = merged_row[p1_bit_reg];
    end

    always_comb begin
        out_next = '0;
        case (p1_op_reg)
            OP_ADD: begin
                out_next.status = p1_bad_reg;
            end
            OP_DATA: begin
                out_next.data_out = (mark_hit ? fill_value_reg : p1_data_reg) & DATA_MASK;
                out_next.last_out = p1_last_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mark_mem[p1_row_reg] <= p1_wdata;
        end
        if (s_accept) begin
            rd_data_reg <= mark_mem[s_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_size_reg     <= DIM_SIZE_W'(1);
            inner_size_reg   <= INNER_SIZE_W'(1);
            fill_value_reg   <= '0;
            inner_count_reg  <= '0;
            dim_position_reg <= '0;
            row_valid_reg    <= '0;
            p1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DIM_SIZE:   dim_size_reg   <= cfg_data[DIM_SIZE_W-1:0];
                    CFG_INNER_SIZE: inner_size_reg <= cfg_data[INNER_SIZE_W-1:0];
                    CFG_FILL_VALUE: fill_value_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            inner_count_reg  <= inner_count_next;
            dim_position_reg <= dim_position_next;
            row_valid_reg    <= row_valid_next;
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_op_reg     <= s_req.opcode;
            p1_data_reg   <= s_req.data_in;
            p1_last_reg   <= s_req.last_in;
            p1_bad_reg    <= idx_bad;
            p1_row_reg    <= s_row;
            p1_bit_reg    <= s_bit;
            p1_fwd_reg    <= mem_we && (p1_row_reg == s_row);
            p1_rvalid_reg <= row_valid_reg[s_row];
        end
        if (mem_we) begin
            last_wdata_reg <= p1_wdata;
        end
        if (p1_adv) begin
            out_reg <= out_next;
        end
    end

endmodule
